### hw/rtl/epd_pkg.sv
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types, constants and controller commands of the position loop core.
// ----------------------------------------------------------------------------
package epd_pkg;

   localparam int VEL_TAPS   = 5;
   localparam int COUNT_BITS = 16;
   localparam int SUM_BITS   = 32 + $clog2(VEL_TAPS + 1);

   // window average: long division by VEL_TAPS, one 16-bit digit per step,
   // each digit found by a reciprocal multiply
   localparam int AVG_CHUNK  = 16;
   localparam int AVG_STEPS  = (SUM_BITS + AVG_CHUNK - 1) / AVG_CHUNK;
   localparam int AVG_BITS   = AVG_STEPS * AVG_CHUNK;
   localparam int AREM_BITS  = $clog2(VEL_TAPS);
   localparam int ADIV_BITS  = AREM_BITS + AVG_CHUNK;
   localparam int AVG_SHIFT  = 25;
   localparam int APROD_BITS = ADIV_BITS + AVG_SHIFT;
   localparam int AVG_RECIP  = (2 ** AVG_SHIFT + VEL_TAPS - 1) / VEL_TAPS;

   localparam logic [15:0] DUTY_MAX  = 16'hFFFF;
   localparam logic [9:0]  MS_PER_S  = 10'd1000;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_GOTO  = 3'd1;
   localparam logic [2:0] OP_SET   = 3'd2;
   localparam logic [2:0] OP_OFF   = 3'd3;
   localparam logic [2:0] OP_BRAKE = 3'd4;

   localparam logic [1:0] DIR_COAST = 2'd0;
   localparam logic [1:0] DIR_BRAKE = 2'd1;
   localparam logic [1:0] DIR_FWD   = 2'd2;
   localparam logic [1:0] DIR_BACK  = 2'd3;

   localparam logic [1:0] CSR_KP    = 2'd0;
   localparam logic [1:0] CSR_KD    = 2'd1;
   localparam logic [1:0] CSR_SCALE = 2'd2;
   localparam logic [1:0] CSR_MAXST = 2'd3;

   typedef struct packed {
      logic [2:0]         op;
      logic [15:0]        enc_count;
      logic [9:0]         elapsed_ms;
      logic signed [19:0] cmd_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         drive_dir;
      logic [15:0]        duty;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
   } rsp_type;

   // controller -> datapath commands (one-hot pulses)
   typedef struct packed {
      logic load;     // latch request
      logic mul_v;    // scale*step into dpos, latch elapsed ms
      logic div_start;
      logic div_step;
      logic vel_upd;  // window/sum update, start averaging divide
      logic avg_step;
      logic err;      // form e, de
      logic mul_p;    // kp*e
      logic mul_d;    // kd*de
      logic drive;    // form drive and result
      logic misc;     // goto/set/off/brake/unknown result
   } cmd_type;

   typedef struct packed {
      logic is_tick;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

### hw/rtl/encoder_pd_motor_position_loop_core.sv
// ----------------------------------------------------------------------------
// encoder_pd_motor_position_loop_core
// PD position loop for one motor with a quadrature encoder.
// ----------------------------------------------------------------------------
// A tick passes through a 43-step restoring divider that forms the velocity
// sample, a 3-step reciprocal divider that averages the window 16 bits at a
// time, and a multiply step each for kp*e and kd*de before rsp_valid rises.
// Goto, set, off, brake and unused op codes raise rsp_valid from the dispatch
// state. One request is in flight at a time; the next is taken as soon as the
// result register is free, which may be in the cycle its result beat leaves.
module encoder_pd_motor_position_loop_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  epd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output epd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import epd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   epd_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   epd_datapath u_dp (
      .clock, .reset, .req(req_data), .csr_valid, .csr_index, .csr_data,
      .cmd, .sts, .rsp(rsp_data)
   );

endmodule

### hw/rtl/epd_datapath.sv
// ----------------------------------------------------------------------------
// epd_datapath
// Loop state, multipliers and serial dividers of the position loop.
// ----------------------------------------------------------------------------
module epd_datapath (
   input  logic             clock,
   input  logic             reset,
   input  epd_pkg::req_type req,
   input  logic             csr_valid,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data,
   input  epd_pkg::cmd_type cmd,
   output epd_pkg::sts_type sts,
   output epd_pkg::rsp_type rsp
);
   import epd_pkg::*;

   logic [23:0] kp_ff, kd_ff;
   logic [15:0] scale_ff;
   logic [14:0] maxst_ff;
   req_type     req_ff;
   logic [COUNT_BITS-1:0] prev_count_ff;
   logic signed [31:0] pos_ff, tgt_ff, perr_ff;
   logic signed [31:0] win_ff [VEL_TAPS];
   logic signed [SUM_BITS-1:0] sum_ff;
   logic signed [32:0] dpos_ff;
   logic signed [32:0] e_ff, de_ff;
   logic signed [58:0] prod_ff;
   logic signed [58:0] acc_ff;
   // magnitude divider: dpos*1000 up to 43 bits / 10-bit ms
   logic [42:0] quo_ff;
   logic [10:0] rem_ff;
   logic        neg_ff;
   logic [9:0]  ms_ff;
   // averaging divider: |sum| / VEL_TAPS, one 16-bit digit per step
   logic [AVG_BITS-1:0]  aq_ff;
   logic [AREM_BITS-1:0] arem_ff;
   logic                 aneg_ff;
   logic signed [31:0]   vel_ff;
   rsp_type              rsp_ff;

   logic signed [COUNT_BITS-1:0] step;
   logic signed [COUNT_BITS-1:0] step_ok;
   logic signed [32:0] dpos_new;
   logic signed [32:0] mag_step;
   logic [32:0] dpos_abs;
   logic [10:0] rem_sh;
   logic [SUM_BITS-1:0] sum_abs;
   logic [ADIV_BITS-1:0] adiv;
   logic [APROD_BITS-1:0] aprod;
   logic [AVG_CHUNK-1:0] adig;
   logic [AREM_BITS-1:0] arem_new;
   logic signed [63:0] vsig;
   logic signed [31:0] vnew;
   logic signed [SUM_BITS-1:0] sum_new;
   logic signed [31:0] pos_set;
   logic signed [32:0] e_new;
   logic [58:0] amag;
   logic [38:0] mag20;
   logic [15:0] dmag;

   assign sts.is_tick = (req_ff.op == OP_TICK);
   assign rsp = rsp_ff;

   always_comb begin
      step     = COUNT_BITS'(req_ff.enc_count) - prev_count_ff;
      mag_step = (step < 0) ? -33'(step) : 33'(step);
      step_ok  = (mag_step > 33'(maxst_ff)) ? '0 : step;
      dpos_new = $signed({1'b0, scale_ff}) * 33'(step_ok);
      dpos_abs = dpos_ff[32] ? 33'(-dpos_ff) : 33'(dpos_ff);
      rem_sh   = {rem_ff[9:0], quo_ff[42]};
      vsig     = neg_ff ? -64'($signed({1'b0, quo_ff})) : 64'($signed({1'b0, quo_ff}));
      vnew     = sat32(vsig);
      sum_new  = sum_ff - SUM_BITS'(win_ff[0]) + SUM_BITS'(vnew);
      sum_abs  = sum_new[SUM_BITS-1] ? SUM_BITS'(-sum_new) : SUM_BITS'(sum_new);
      adiv     = {arem_ff, aq_ff[AVG_BITS-1 -: AVG_CHUNK]};
      aprod    = APROD_BITS'(adiv) * APROD_BITS'(AVG_RECIP);
      adig     = aprod[AVG_SHIFT +: AVG_CHUNK];
      arem_new = AREM_BITS'(adiv - ADIV_BITS'(adig) * ADIV_BITS'(VEL_TAPS));
      pos_set  = 32'(req_ff.cmd_value) <<< 12;
      e_new    = 33'(sat32(64'(pos_ff) - 64'(tgt_ff)));
      amag     = acc_ff[58] ? 59'(-acc_ff) : 59'(acc_ff);
      mag20    = amag[58:20];
      dmag     = (mag20 > 39'(DUTY_MAX)) ? DUTY_MAX : mag20[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= 24'd256000; kd_ff <= 24'd256000;
         scale_ff <= 16'd4825; maxst_ff <= 15'd2000;
         prev_count_ff <= '0; pos_ff <= '0; tgt_ff <= '0; perr_ff <= '0;
         sum_ff <= '0;
         for (int i = 0; i < VEL_TAPS; i++) win_ff[i] <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_KP:    kp_ff    <= csr_data[23:0];
               CSR_KD:    kd_ff    <= csr_data[23:0];
               CSR_SCALE: scale_ff <= csr_data[15:0];
               CSR_MAXST: maxst_ff <= csr_data[14:0];
               default: ;
            endcase
         end
         if (cmd.mul_v) begin
            prev_count_ff <= req_ff.enc_count;
         end
         if (cmd.div_start) begin
            pos_ff <= pos_ff + dpos_ff[31:0];
         end
         if (cmd.vel_upd) begin
            for (int i = 0; i < VEL_TAPS - 1; i++) win_ff[i] <= win_ff[i+1];
            win_ff[VEL_TAPS-1] <= vnew;
            sum_ff <= sum_new;
         end
         if (cmd.drive) perr_ff <= e_ff[31:0];
         if (cmd.misc) begin
            if (req_ff.op == OP_GOTO) tgt_ff <= pos_set;
            if (req_ff.op == OP_SET) begin
               pos_ff <= pos_set; tgt_ff <= pos_set; perr_ff <= '0;
               sum_ff <= '0;
               for (int i = 0; i < VEL_TAPS; i++) win_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req;
      if (cmd.mul_v) begin
         dpos_ff <= dpos_new;
         ms_ff   <= (req_ff.elapsed_ms == '0) ? 10'd1 : req_ff.elapsed_ms;
      end
      if (cmd.div_start) begin
         neg_ff <= dpos_ff[32];
         quo_ff <= 43'(dpos_abs) * 43'(MS_PER_S);
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_sh >= {1'b0, ms_ff}) begin
            rem_ff <= rem_sh - {1'b0, ms_ff};
            quo_ff <= {quo_ff[41:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[41:0], 1'b0};
         end
      end
      if (cmd.vel_upd) begin
         aneg_ff <= sum_new[SUM_BITS-1];
         aq_ff   <= AVG_BITS'(sum_abs);
         arem_ff <= '0;
      end
      if (cmd.avg_step) begin
         aq_ff   <= {aq_ff[AVG_BITS-AVG_CHUNK-1:0], adig};
         arem_ff <= arem_new;
      end
      if (cmd.err) begin
         e_ff  <= e_new;
         de_ff <= e_new - 33'(perr_ff);
      end
      if (cmd.mul_p) prod_ff <= 59'($signed({1'b0, kp_ff}) * e_ff);
      if (cmd.mul_d) acc_ff  <= -(prod_ff + 59'($signed({1'b0, kd_ff}) * de_ff));
      if (cmd.drive) begin
         rsp_ff.drive_dir <= (!acc_ff[58] && dmag != '0) ? DIR_FWD : DIR_BACK;
         rsp_ff.duty      <= dmag;
         rsp_ff.position  <= pos_ff;
         rsp_ff.velocity  <= vel_ff;
      end
      if (cmd.misc) begin
         rsp_ff.drive_dir <= (req_ff.op == OP_BRAKE) ? DIR_BRAKE : DIR_COAST;
         rsp_ff.duty      <= (req_ff.op == OP_BRAKE) ? DUTY_MAX : '0;
         rsp_ff.position  <= (req_ff.op == OP_SET) ? pos_set : pos_ff;
         rsp_ff.velocity  <= (req_ff.op == OP_SET) ? '0 : vel_ff;
      end
      if (reset) vel_ff <= '0;
      else if (cmd.err) vel_ff <= sat32(aneg_ff ? -64'($signed({1'b0, aq_ff}))
                                                : 64'($signed({1'b0, aq_ff})));
      else if (cmd.misc && req_ff.op == OP_SET) vel_ff <= '0;
   end

endmodule

### hw/rtl/epd_control.sv
// ----------------------------------------------------------------------------
// epd_control
// Sequencer that steps the datapath through one request.
// ----------------------------------------------------------------------------
module epd_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  epd_pkg::sts_type sts,
   output epd_pkg::cmd_type cmd
);
   import epd_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_MULV = 4'd2,
      S_DIVS = 4'd3, S_DIV = 4'd4, S_VEL = 4'd5, S_AVG = 4'd6, S_ERR = 4'd7,
      S_MULP = 4'd8, S_MULD = 4'd9, S_DRV = 4'd10;
   localparam logic [5:0] DIV_LAST = 6'd42;
   localparam logic [5:0] AVG_LAST = 6'(AVG_STEPS - 1);

   logic [3:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       rv_ff, rv_in;

   assign req_ready = (state_ff == S_IDLE) && (!rv_ff || rsp_ready);
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rv_in    = rv_ff && !rsp_ready;
      cmd      = '0;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            cmd.load = 1'b1; state_in = S_DISP;
         end
         S_DISP: if (sts.is_tick) state_in = S_MULV;
                 else begin cmd.misc = 1'b1; rv_in = 1'b1; state_in = S_IDLE; end
         S_MULV: begin cmd.mul_v = 1'b1; state_in = S_DIVS; end
         S_DIVS: begin cmd.div_start = 1'b1; cnt_in = '0; state_in = S_DIV; end
         S_DIV: begin
            cmd.div_step = 1'b1; cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) state_in = S_VEL;
         end
         S_VEL: begin cmd.vel_upd = 1'b1; cnt_in = '0; state_in = S_AVG; end
         S_AVG: begin
            cmd.avg_step = 1'b1; cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == AVG_LAST) state_in = S_ERR;
         end
         S_ERR:  begin cmd.err = 1'b1; state_in = S_MULP; end
         S_MULP: begin cmd.mul_p = 1'b1; state_in = S_MULD; end
         S_MULD: begin cmd.mul_d = 1'b1; state_in = S_DRV; end
         S_DRV:  begin cmd.drive = 1'b1; rv_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; rv_ff <= rv_in;
      end
   end

endmodule

### hw/rtl/epd_checker.sv
// ----------------------------------------------------------------------------
// epd_checker
// Port-level checks of the position loop core.
// ----------------------------------------------------------------------------
module epd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input epd_pkg::rsp_type rsp_data
);
   import epd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid || !$past(rsp_valid))
      else $error("result appeared without work");

   a_brake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drive_dir == DIR_BRAKE |-> rsp_data.duty == DUTY_MAX)
      else $error("brake without full duty");

endmodule

bind encoder_pd_motor_position_loop_core epd_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);

### test/encoder_pd_motor_position_loop_core_tb.sv
// ----------------------------------------------------------------------------
// encoder_pd_motor_position_loop_core_tb
// Drives tick, goto, set, off, brake and unused commands through the position
// loop under several gain and scale settings. An in-bench copy of the loop
// predicts each response, and the monitor checks every response beat in order.
// ----------------------------------------------------------------------------
module encoder_pd_motor_position_loop_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import epd_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_WAIT  = 150;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   encoder_pd_motor_position_loop_core dut (.*);

   always #2 clock = ~clock;

   // loop state mirror
   longint gain_p = 256000, gain_d = 256000, mm_per_count = 4825, step_cap = 2000;
   logic [15:0] last_count = '0;
   int     pos_q12 = 0, target_q12 = 0, last_err = 0;
   int     vel_taps [VEL_TAPS];
   longint vel_total = 0;

   req_type cmd_fifo [$];
   rsp_type rsp_due [$];
   int      errors = 0;
   int      send_idle_pct = 11, recv_idle_pct = 71;
   logic    req_taken = 1'b0;
   int      quiet_cycles = 0;
   logic [15:0] gen_count = '0;

   function automatic int clamp_i32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic void clear_history();
      foreach (vel_taps[i]) vel_taps[i] = 0;
      vel_total = 0;
      last_err = 0;
   endfunction

   function automatic rsp_type loop_predict(req_type r);
      rsp_type     o;
      logic [15:0] diff;
      longint      d, dpos, ms, v, e, de, acc, mag;
      o = '0;
      case (r.op)
         OP_TICK: begin
            diff = r.enc_count - last_count;
            d = longint'($signed(diff));
            if (d > step_cap || d < -step_cap) d = 0;
            last_count = r.enc_count;
            dpos = mm_per_count * d;
            pos_q12 = int'(longint'(pos_q12) + dpos);
            ms = (r.elapsed_ms == 0) ? 1 : longint'(r.elapsed_ms);
            v = clamp_i32(dpos * 1000 / ms);
            vel_total -= vel_taps[0];
            for (int i = 0; i < VEL_TAPS - 1; i++) vel_taps[i] = vel_taps[i + 1];
            vel_taps[VEL_TAPS - 1] = int'(v);
            vel_total += v;
            e = clamp_i32(longint'(pos_q12) - longint'(target_q12));
            de = e - longint'(last_err);
            acc = -(gain_p * e + gain_d * de);
            mag = (acc < 0) ? -acc : acc;
            mag = mag >>> 20;
            if (mag > 65535) mag = 65535;
            o.drive_dir = (acc > 0 && mag > 0) ? DIR_FWD : DIR_BACK;
            o.duty = mag[15:0];
            last_err = int'(e);
         end
         OP_GOTO: target_q12 = int'(longint'(r.cmd_value) * 4096);
         OP_SET: begin
            pos_q12 = int'(longint'(r.cmd_value) * 4096);
            target_q12 = pos_q12;
            clear_history();
         end
         OP_OFF: o.drive_dir = DIR_COAST;
         OP_BRAKE: begin
            o.drive_dir = DIR_BRAKE;
            o.duty = DUTY_MAX;
         end
         default: ;
      endcase
      o.position = pos_q12;
      o.velocity = clamp_i32(vel_total / VEL_TAPS);
      return o;
   endfunction

   function automatic void log_mismatch(string what, longint want, longint got);
      errors++;
      if (errors <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
   endfunction

   // driver: hold the beat until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (!req_valid || req_taken) begin
            if (cmd_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= cmd_fifo.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check responses, predict on accepted requests, track config
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               log_mismatch("unexpected beat", 0, 1);
            end else begin
               want = rsp_due.pop_front();
               if (rsp_data.drive_dir !== want.drive_dir)
                  log_mismatch("drive_dir", want.drive_dir, rsp_data.drive_dir);
               if (rsp_data.duty !== want.duty)
                  log_mismatch("duty", want.duty, rsp_data.duty);
               if (rsp_data.position !== want.position)
                  log_mismatch("position", want.position, rsp_data.position);
               if (rsp_data.velocity !== want.velocity)
                  log_mismatch("velocity", want.velocity, rsp_data.velocity);
            end
         end
         if (req_valid && req_ready) rsp_due.push_back(loop_predict(req_data));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KP:    gain_p = csr_data[23:0];
               CSR_KD:    gain_d = csr_data[23:0];
               CSR_SCALE: mm_per_count = csr_data[15:0];
               CSR_MAXST: step_cap = csr_data[14:0];
               default: ;
            endcase
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
             || (cmd_fifo.size() == 0 && rsp_due.size() == 0 && !csr_valid && !req_valid))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("encoder_pd_motor_position_loop_core_tb: done, errors");
            $finish;
         end
      end
   end

   function automatic req_type make_cmd(logic [2:0] op, logic [15:0] cnt, logic [9:0] ms,
                                        logic signed [19:0] val);
      req_type r;
      r.op = op;
      r.enc_count = cnt;
      r.elapsed_ms = ms;
      r.cmd_value = val;
      if (op == OP_TICK) gen_count = cnt;
      return r;
   endfunction

   function automatic req_type random_cmd();
      int pick, lim, step;
      logic [9:0] ms;
      logic signed [19:0] val;
      pick = $urandom_range(99);
      lim  = int'(step_cap);
      ms   = ($urandom_range(19) == 0) ? 10'($urandom) : 10'($urandom_range(1, 50));
      val  = $urandom_range(1) ? 20'($urandom) : 20'($signed($urandom_range(4000)) - 2000);
      if (pick < 70) begin
         if ($urandom_range(9) == 0) step = lim + 1 + $urandom_range(200);
         else step = $urandom_range(lim < 400 ? lim : 400);
         if ($urandom_range(1)) step = -step;
         return make_cmd(OP_TICK, gen_count + 16'(step), ms, val);
      end
      if (pick < 78) return make_cmd(OP_TICK, 16'($urandom), ms, val);
      if (pick < 86) return make_cmd(OP_GOTO, 16'($urandom), ms, val);
      if (pick < 90) return make_cmd(OP_SET, 16'($urandom), ms, val);
      if (pick < 94) return make_cmd(OP_OFF, 16'($urandom), ms, val);
      if (pick < 97) return make_cmd(OP_BRAKE, 16'($urandom), ms, val);
      return make_cmd(3'($urandom_range(5, 7)), 16'($urandom), ms, val);
   endfunction

   task automatic drain();
      while (cmd_fifo.size() > 0 || rsp_due.size() > 0 || req_valid) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) cmd_fifo.push_back(random_cmd());
      drain();
   endtask

   initial begin
      foreach (vel_taps[i]) vel_taps[i] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every op, step limit, wrap, zero elapsed time
      cmd_fifo.push_back(make_cmd(OP_SET, 16'h0000, 10'd1, 20'sh7FFFF));
      cmd_fifo.push_back(make_cmd(OP_SET, 16'hFFFF, 10'd1, 20'sh80000));
      cmd_fifo.push_back(make_cmd(OP_GOTO, 16'h0000, 10'd1023, 20'sh7FFFF));
      cmd_fifo.push_back(make_cmd(OP_TICK, 16'd2000, 10'd1, 20'sd0));
      cmd_fifo.push_back(make_cmd(OP_TICK, 16'd0, 10'd0, 20'sd0));
      cmd_fifo.push_back(make_cmd(OP_TICK, 16'd2001, 10'd1023, 20'sd0));
      cmd_fifo.push_back(make_cmd(OP_TICK, 16'hFFFF, 10'd3, 20'sd0));
      cmd_fifo.push_back(make_cmd(OP_TICK, 16'h0000, 10'd3, 20'sd0));
      cmd_fifo.push_back(make_cmd(OP_TICK, 16'h8000, 10'd5, 20'sd0));
      cmd_fifo.push_back(make_cmd(OP_GOTO, 16'hFFFF, 10'd0, 20'sh80000));
      cmd_fifo.push_back(make_cmd(OP_TICK, 16'h8010, 10'd7, 20'sd0));
      cmd_fifo.push_back(make_cmd(OP_OFF, 16'hFFFF, 10'h3FF, 20'shFFFFF));
      cmd_fifo.push_back(make_cmd(OP_BRAKE, 16'hFFFF, 10'h3FF, 20'shFFFFF));
      cmd_fifo.push_back(make_cmd(3'd5, 16'hFFFF, 10'h3FF, 20'shFFFFF));
      cmd_fifo.push_back(make_cmd(3'd6, 16'h0000, 10'h000, 20'sh00000));
      cmd_fifo.push_back(make_cmd(3'd7, 16'h5555, 10'h2AA, 20'sh55555));
      cmd_fifo.push_back(make_cmd(OP_SET, 16'h0000, 10'd1, 20'sd0));
      cmd_fifo.push_back(make_cmd(OP_TICK, 16'h800F, 10'd1, 20'sd0));
      drain();
      run_random(380);

      write_reg(CSR_KP, 32'hFFFFFFFF);
      write_reg(CSR_KD, 32'h0);
      write_reg(CSR_SCALE, 32'hFFFF);
      write_reg(CSR_MAXST, 32'h7FFF);
      run_random(330);

      send_idle_pct = 71;
      recv_idle_pct = 11;
      write_reg(CSR_KP, 32'h0);
      write_reg(CSR_KD, 32'h00FFFFFF);
      write_reg(CSR_SCALE, 32'h0);
      write_reg(CSR_MAXST, 32'h0);
      run_random(200);
      write_reg(CSR_SCALE, 32'd4825);
      write_reg(CSR_MAXST, 32'd1);
      run_random(150);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_KP, $urandom_range(1000, 3000000));
      write_reg(CSR_KD, $urandom_range(1000, 3000000));
      write_reg(CSR_SCALE, $urandom_range(1, 65535));
      write_reg(CSR_MAXST, $urandom_range(100, 32767));
      run_random(380);

      if (errors == 0)
         $display("encoder_pd_motor_position_loop_core_tb: done, clean");
      else
         $display("encoder_pd_motor_position_loop_core_tb: done, errors");
      $finish;
   end

endmodule

### sim.f
hw/rtl/epd_pkg.sv
hw/rtl/epd_datapath.sv
hw/rtl/epd_control.sv
hw/rtl/encoder_pd_motor_position_loop_core.sv
hw/rtl/epd_checker.sv
test/encoder_pd_motor_position_loop_core_tb.sv
